/* hw/rtl/agbp_pkg.sv */
// ----------------------------------------------------------------------------
// agbp_pkg: shared definitions for the ambient gradient bloom pixel painter
// Widths, fixed-point constants, interface structs and the channel blend.
// ----------------------------------------------------------------------------
`default_nettype none

package agbp_pkg;

    localparam int COORD_W       = 10;
    localparam int DIM_W         = 11;
    localparam int MAX_DIMENSION = 1024;
    localparam int Q_W           = 17;
    localparam int WGT_W         = 16;
    localparam int CH_W          = 16;

    localparam int NUM_W         = COORD_W + 16;
    localparam int DIV_STEP      = 2;
    localparam int DIV_STAGES    = NUM_W / DIV_STEP;

    localparam int RECIP_K       = 17;
    localparam int RCP_W         = 20;
    localparam int DX_W          = 18;
    localparam int SQ_W          = 2 * DX_W;
    localparam int SQ_IN_W       = 32;
    localparam int SQ_ROOT_W     = 16;
    localparam int SQ_REM_W      = 18;
    localparam int SQ_STEP       = 2;
    localparam int SQ_STAGES     = SQ_ROOT_W / SQ_STEP;

    // Axis order: accent x, accent y, top x, top y.
    localparam logic [15:0] AXIS_CENTER [4] = '{16'd51118, 16'd17039, 16'd32768, 16'd2621};
    localparam logic [15:0] AXIS_RADIUS [4] = '{16'd29491, 16'd19661, 16'd43909, 16'd28836};
    localparam logic [RCP_W-1:0] AXIS_RECIP [4] = '{
        RCP_W'((64'd1 << (16 + RECIP_K)) / 64'd29491),
        RCP_W'((64'd1 << (16 + RECIP_K)) / 64'd19661),
        RCP_W'((64'd1 << (16 + RECIP_K)) / 64'd43909),
        RCP_W'((64'd1 << (16 + RECIP_K)) / 64'd28836)
    };
    // Bloom order: accent, top.
    localparam logic [15:0] BLOOM_GAIN [2] = '{16'd40632, 16'd55706};

    localparam logic [7:0]  BG_COLOR [3] = '{8'd7, 8'd7, 8'd9};
    localparam logic [Q_W-1:0] WASH_TINT = 17'd10486;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH    = 3'd0,
        REG_FRAME_HEIGHT   = 3'd1,
        REG_DOMINANT_RED   = 3'd2,
        REG_DOMINANT_GREEN = 3'd3,
        REG_DOMINANT_BLUE  = 3'd4,
        REG_ACCENT_RED     = 3'd5,
        REG_ACCENT_GREEN   = 3'd6,
        REG_ACCENT_BLUE    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [Q_W-1:0] fx;
        logic [Q_W-1:0] fy;
    } norm_t;

    typedef struct packed {
        logic [WGT_W-1:0] wa;
        logic [WGT_W-1:0] wt;
        logic [Q_W-1:0]   fy;
    } bloom_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Blend a toward b by weight t, rounded half up.
    function automatic logic [CH_W-1:0] blend_q16(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b,
                                                  input logic [Q_W-1:0] t);
        logic signed [17:0] diff;
        logic signed [35:0] prod;
        logic signed [36:0] acc;
        diff = $signed({2'b00, b}) - $signed({2'b00, a});
        prod = diff * $signed({1'b0, t});
        acc  = $signed({5'b00000, a, 16'h0000}) + 37'(prod) + 37'sd32768;
        return acc[31:16];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/agbp_norm.sv */
// ----------------------------------------------------------------------------
// agbp_norm: coordinate normalizer
// Clamps both coordinates to the frame and divides by the dimension minus one
// in a pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module agbp_norm (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [agbp_pkg::COORD_W-1:0]  column,
    input  wire logic [agbp_pkg::COORD_W-1:0]  row,
    input  wire logic [agbp_pkg::DIM_W-1:0]    width,
    input  wire logic [agbp_pkg::DIM_W-1:0]    height,
    output logic                               out_valid,
    output agbp_pkg::norm_t                    out_data
);
    import agbp_pkg::*;

    logic                 v_reg    [DIV_STAGES+1];
    logic [NUM_W-1:0]     num_reg  [DIV_STAGES+1][2];
    logic [COORD_W-1:0]   rem_reg  [DIV_STAGES+1][2];
    logic [Q_W-1:0]       q_reg    [DIV_STAGES+1][2];
    logic [COORD_W-1:0]   div_reg  [DIV_STAGES+1][2];
    logic                 zero_reg [DIV_STAGES+1][2];

    logic [NUM_W-1:0]     num_next [DIV_STAGES+1][2];
    logic [COORD_W-1:0]   rem_next [DIV_STAGES+1][2];
    logic [Q_W-1:0]       q_next   [DIV_STAGES+1][2];
    logic [COORD_W-1:0]   div_next [2];
    logic                 zero_next[2];

    assign in_ready = en | ~v_reg[0];

    always_comb
    begin
        logic [COORD_W-1:0] pos;
        logic [DIM_W-1:0]   dim;
        logic [DIM_W-1:0]   dim_eff;
        logic [COORD_W-1:0] dmax;
        logic [COORD_W-1:0] pc;
        logic [NUM_W-1:0]   n;
        logic [COORD_W-1:0] r;
        logic [Q_W-1:0]     q;
        logic [COORD_W:0]   t;
        for (int l = 0; l < 2; l++)
        begin
            pos = (l == 0) ? column : row;
            dim = (l == 0) ? width : height;
            if (dim == '0)
            begin
                dim_eff = DIM_W'(1);
            end
            else if (dim > DIM_W'(MAX_DIMENSION))
            begin
                dim_eff = DIM_W'(MAX_DIMENSION);
            end
            else
            begin
                dim_eff = dim;
            end
            dmax = COORD_W'(dim_eff - DIM_W'(1));
            pc = (pos > dmax) ? dmax : pos;
            div_next[l]    = dmax;
            zero_next[l]   = (dim_eff == DIM_W'(1));
            num_next[0][l] = {pc, 16'h0000} + NUM_W'(dmax >> 1);
            rem_next[0][l] = '0;
            q_next[0][l]   = '0;
        end
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                n = num_reg[s-1][l];
                r = rem_reg[s-1][l];
                q = q_reg[s-1][l];
                for (int k = 0; k < DIV_STEP; k++)
                begin
                    t = {r, n[NUM_W-1]};
                    n = n << 1;
                    if (t >= {1'b0, div_reg[s-1][l]})
                    begin
                        r = COORD_W'(t - {1'b0, div_reg[s-1][l]});
                        q = {q[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r = t[COORD_W-1:0];
                        q = {q[Q_W-2:0], 1'b0};
                    end
                end
                num_next[s][l] = n;
                rem_next[s][l] = r;
                q_next[s][l]   = q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                v_reg[0] <= in_valid;
            end
            if (en)
            begin
                for (int s = 1; s <= DIV_STAGES; s++)
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            for (int l = 0; l < 2; l++)
            begin
                num_reg[0][l]  <= num_next[0][l];
                rem_reg[0][l]  <= rem_next[0][l];
                q_reg[0][l]    <= q_next[0][l];
                div_reg[0][l]  <= div_next[l];
                zero_reg[0][l] <= zero_next[l];
            end
        end
        if (en)
        begin
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    num_reg[s][l]  <= num_next[s][l];
                    rem_reg[s][l]  <= rem_next[s][l];
                    q_reg[s][l]    <= q_next[s][l];
                    div_reg[s][l]  <= div_reg[s-1][l];
                    zero_reg[s][l] <= zero_reg[s-1][l];
                end
            end
        end
    end

    assign out_valid   = v_reg[DIV_STAGES];
    assign out_data.fx = zero_reg[DIV_STAGES][0] ? '0 : q_reg[DIV_STAGES][0];
    assign out_data.fy = zero_reg[DIV_STAGES][1] ? '0 : q_reg[DIV_STAGES][1];

endmodule

`default_nettype wire

/* hw/rtl/agbp_bloom.sv */
// ----------------------------------------------------------------------------
// agbp_bloom: bloom weight pipeline
// Elliptical distance of the pixel from both bloom centers, a pipelined
// square root, and the linear falloff scaled by each bloom's intensity.
// ----------------------------------------------------------------------------
`default_nettype none

module agbp_bloom (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  agbp_pkg::norm_t in_data,
    output logic            out_valid,
    output agbp_pkg::bloom_t out_data
);
    import agbp_pkg::*;

    localparam int PRE = 6;
    localparam int LAT = PRE + SQ_STAGES + 1;

    logic                 v_reg  [LAT];
    logic [Q_W-1:0]       fy_reg [LAT];

    logic [Q_W-1:0]       a_reg  [4];
    logic [Q_W-1:0]       a2_reg [4];
    logic [RCP_W-1:0]     q0_reg [4];
    logic [RCP_W-1:0]     q1_reg [4];
    logic [DX_W-1:0]      r_reg  [4];
    logic [DX_W-1:0]      dx_reg [4];
    logic [SQ_W-1:0]      sq_reg [4];

    logic [SQ_IN_W-1:0]   sx_reg   [SQ_STAGES+1][2];
    logic [SQ_REM_W-1:0]  rem_reg  [SQ_STAGES+1][2];
    logic [SQ_ROOT_W-1:0] root_reg [SQ_STAGES+1][2];
    logic                 big_reg  [SQ_STAGES+1][2];

    logic [SQ_IN_W-1:0]   sx_next   [SQ_STAGES+1][2];
    logic [SQ_REM_W-1:0]  rem_next  [SQ_STAGES+1][2];
    logic [SQ_ROOT_W-1:0] root_next [SQ_STAGES+1][2];

    logic [WGT_W-1:0]     w_reg [2];

    always_comb
    begin
        logic [SQ_IN_W-1:0]   x;
        logic [SQ_REM_W-1:0]  r;
        logic [SQ_ROOT_W-1:0] rt;
        logic [SQ_REM_W+1:0]  t;
        logic [SQ_REM_W+1:0]  trial;
        for (int l = 0; l < 2; l++)
        begin
            sx_next[0][l]   = '0;
            rem_next[0][l]  = '0;
            root_next[0][l] = '0;
        end
        for (int s = 1; s <= SQ_STAGES; s++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                x  = sx_reg[s-1][l];
                r  = rem_reg[s-1][l];
                rt = root_reg[s-1][l];
                for (int k = 0; k < SQ_STEP; k++)
                begin
                    t     = {r, x[SQ_IN_W-1:SQ_IN_W-2]};
                    trial = (SQ_REM_W+2)'({rt, 2'b01});
                    x     = x << 2;
                    if (t >= trial)
                    begin
                        r  = SQ_REM_W'(t - trial);
                        rt = {rt[SQ_ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r  = SQ_REM_W'(t);
                        rt = {rt[SQ_ROOT_W-2:0], 1'b0};
                    end
                end
                sx_next[s][l]   = x;
                rem_next[s][l]  = r;
                root_next[s][l] = rt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [Q_W-1:0]      f;
        logic [Q_W+RCP_W-1:0] px;
        logic [36:0]         diff;
        logic [SQ_W:0]       sum;
        logic [Q_W-1:0]      w;
        logic [33:0]         wp;
        if (en)
        begin
            fy_reg[0] <= in_data.fy;
            for (int i = 1; i < LAT; i++)
            begin
                fy_reg[i] <= fy_reg[i-1];
            end
            for (int k = 0; k < 4; k++)
            begin
                f = k[0] ? in_data.fy : in_data.fx;
                a_reg[k] <= (f >= {1'b0, AXIS_CENTER[k]}) ? f - {1'b0, AXIS_CENTER[k]}
                                                           : {1'b0, AXIS_CENTER[k]} - f;
                px = (Q_W+RCP_W)'(a_reg[k]) * (Q_W+RCP_W)'(AXIS_RECIP[k]);
                q0_reg[k] <= RCP_W'(px >> RECIP_K);
                a2_reg[k] <= a_reg[k];
                diff = {4'h0, a2_reg[k], 16'h0000} - 37'(37'(q0_reg[k]) * 37'(AXIS_RADIUS[k]));
                r_reg[k]  <= diff[DX_W-1:0];
                q1_reg[k] <= q0_reg[k];
                dx_reg[k] <= (r_reg[k] >= DX_W'(AXIS_RADIUS[k])) ? DX_W'(q1_reg[k] + 1'b1)
                                                                 : DX_W'(q1_reg[k]);
                sq_reg[k] <= SQ_W'(dx_reg[k]) * SQ_W'(dx_reg[k]);
            end
            for (int l = 0; l < 2; l++)
            begin
                sum = (SQ_W+1)'(sq_reg[2*l]) + (SQ_W+1)'(sq_reg[2*l+1]);
                sx_reg[0][l]   <= sum[SQ_IN_W-1:0];
                big_reg[0][l]  <= |sum[SQ_W:SQ_IN_W];
                rem_reg[0][l]  <= rem_next[0][l];
                root_reg[0][l] <= root_next[0][l];
                for (int s = 1; s <= SQ_STAGES; s++)
                begin
                    sx_reg[s][l]   <= sx_next[s][l];
                    rem_reg[s][l]  <= rem_next[s][l];
                    root_reg[s][l] <= root_next[s][l];
                    big_reg[s][l]  <= big_reg[s-1][l];
                end
                w  = 17'h10000 - {1'b0, root_reg[SQ_STAGES][l]};
                wp = 34'(w) * 34'(BLOOM_GAIN[l]) + 34'd32768;
                w_reg[l] <= big_reg[SQ_STAGES][l] ? '0 : wp[31:16];
            end
        end
    end

    assign out_valid   = v_reg[LAT-1];
    assign out_data.wa = w_reg[0];
    assign out_data.wt = w_reg[1];
    assign out_data.fy = fy_reg[LAT-1];

endmodule

`default_nettype wire

/* hw/rtl/agbp_blend.sv */
// ----------------------------------------------------------------------------
// agbp_blend: color compositing pipeline
// Tinted background, vertical wash, accent bloom, top bloom, then rounding and
// 5-6-5 packing, one stage each, with the packed pixel held in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module agbp_blend (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  agbp_pkg::bloom_t in_data,
    input  agbp_pkg::rgb_t   dominant,
    input  agbp_pkg::rgb_t   accent,
    output logic             out_valid,
    output logic [15:0]      pixel
);
    import agbp_pkg::*;

    localparam int LAT = 5;

    logic              v_reg [LAT];
    logic [Q_W-1:0]    fy_reg;
    logic [WGT_W-1:0]  wa_reg [2];
    logic [WGT_W-1:0]  wt_reg [3];
    logic [CH_W-1:0]   top_reg  [3];
    logic [CH_W-1:0]   wash_reg [3];
    logic [CH_W-1:0]   acc_reg  [3];
    logic [CH_W-1:0]   dom_reg  [3];
    logic [15:0]       pixel_reg;

    logic [7:0] dom_c [3];
    logic [7:0] acc_c [3];

    assign dom_c[0] = dominant.red;
    assign dom_c[1] = dominant.green;
    assign dom_c[2] = dominant.blue;
    assign acc_c[0] = accent.red;
    assign acc_c[1] = accent.green;
    assign acc_c[2] = accent.blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [CH_W-1:0] sat;
        logic [8:0]      by [3];
        if (en)
        begin
            fy_reg    <= in_data.fy;
            wa_reg[0] <= in_data.wa;
            wa_reg[1] <= wa_reg[0];
            wt_reg[0] <= in_data.wt;
            wt_reg[1] <= wt_reg[0];
            wt_reg[2] <= wt_reg[1];
            for (int c = 0; c < 3; c++)
            begin
                top_reg[c]  <= blend_q16({BG_COLOR[c], 8'h00}, {dom_c[c], 8'h00}, WASH_TINT);
                wash_reg[c] <= blend_q16(top_reg[c], {BG_COLOR[c], 8'h00}, fy_reg);
                acc_reg[c]  <= blend_q16(wash_reg[c], {acc_c[c], 8'h00}, {1'b0, wa_reg[1]});
                dom_reg[c]  <= blend_q16(acc_reg[c], {dom_c[c], 8'h00}, {1'b0, wt_reg[2]});
                sat   = (dom_reg[c] > 16'hFF00) ? 16'hFF00 : dom_reg[c];
                by[c] = 9'((17'(sat) + 17'd128) >> 8);
            end
            pixel_reg <= {by[0][7:3], by[1][7:2], by[2][7:3]};
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign pixel     = pixel_reg;

endmodule

`default_nettype wire

/* hw/rtl/ambient_gradient_bloom_pixel_top.sv */
// ----------------------------------------------------------------------------
// ambient_gradient_bloom_pixel_top: background painter for one pixel
// Each input transaction carries a pixel coordinate; the block answers with
// one RGB565 background color, a wash with two elliptical blooms over it.
//
// The input stream carries column and row; the output stream carries the
// packed color. One output transaction follows each input transaction, in
// order. An item can enter every cycle while the receiver is ready, so the
// sustained rate is then one pixel per clock. The pipeline has one clamp
// stage and 13 divider stages (two quotient bits each), 15 bloom stages
// including 8 square root stages (two root bits each), and 5 compositing
// stages ending in the output register. The configuration port writes
// frame size and palette registers; the user must see that they are written
// only while no transaction is in flight, which the block does not enforce.
// Reset empties the pipeline and loads the register defaults: a 240 by 240
// frame and mid gray for both palette colors.
// When the receiver stalls, the whole pipeline holds; the first stage keeps
// taking a transaction while it is empty, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_gradient_bloom_pixel_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // column [9:0], row [19:10], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // pixel_rgb565 [15:0]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    import agbp_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    rgb_t             dominant_reg;
    rgb_t             accent_reg;

    logic   en;
    logic   norm_valid;
    norm_t  norm_data;
    logic   bloom_valid;
    bloom_t bloom_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 11'd240;
            height_reg   <= 11'd240;
            dominant_reg <= '{red: 8'd128, green: 8'd128, blue: 8'd128};
            accent_reg   <= '{red: 8'd128, green: 8'd128, blue: 8'd128};
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:    width_reg          <= cfg_data;
                REG_FRAME_HEIGHT:   height_reg         <= cfg_data;
                REG_DOMINANT_RED:   dominant_reg.red   <= cfg_data[7:0];
                REG_DOMINANT_GREEN: dominant_reg.green <= cfg_data[7:0];
                REG_DOMINANT_BLUE:  dominant_reg.blue  <= cfg_data[7:0];
                REG_ACCENT_RED:     accent_reg.red     <= cfg_data[7:0];
                REG_ACCENT_GREEN:   accent_reg.green   <= cfg_data[7:0];
                REG_ACCENT_BLUE:    accent_reg.blue    <= cfg_data[7:0];
            endcase
        end
    end

    assign en = ~m_axis_tvalid | m_axis_tready;

    agbp_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .column    (s_axis_tdata[9:0]),
        .row       (s_axis_tdata[19:10]),
        .width     (width_reg),
        .height    (height_reg),
        .out_valid (norm_valid),
        .out_data  (norm_data)
    );

    agbp_bloom u_bloom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (norm_valid),
        .in_data   (norm_data),
        .out_valid (bloom_valid),
        .out_data  (bloom_data)
    );

    agbp_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (bloom_valid),
        .in_data   (bloom_data),
        .dominant  (dominant_reg),
        .accent    (accent_reg),
        .out_valid (m_axis_tvalid),
        .pixel     (m_axis_tdata)
    );

endmodule

`default_nettype wire
